FILE: src/spcq_pkg.sv
// Shared types and codes for the stable priority class queue.
`timescale 1ns / 1ps
package spcq_pkg;

  // Port field widths
  localparam int IdW  = 16;
  localparam int ClsW = 2;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  // Class code that is never stored
  localparam logic [ClsW-1:0] CLS_INVALID = 2'd3;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_BAD_CLASS = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUMP      = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e_t;

  typedef struct packed {
    logic            command;
    logic [IdW-1:0]  patient_id;
    logic [ClsW-1:0] severity_class;
  } in_item_t;

  typedef struct packed {
    status_e_t       status;
    logic [IdW-1:0]  out_id;
    logic [ClsW-1:0] out_class;
    logic            last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_REPLY,
    S_DUMP_RD,
    S_DUMP_OUT
  } seq_state_t;

endpackage

FILE: src/spcq_mem.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module spcq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data valid in the cycle after re
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/spcq_seq.sv
// Sequencer: scans, shifts and dumps the ordered list held in the entry memory.
`timescale 1ns / 1ps
module spcq_seq #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  spcq_pkg::in_item_t           in_data,
  input  logic                         out_free,
  output logic                         res_load,
  output spcq_pkg::out_item_t          res,
  output logic                         mem_we,
  output logic [$clog2(DEPTH)-1:0]     mem_waddr,
  output logic [ID_BITS+2-1:0]         mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr,
  input  logic [ID_BITS+2-1:0]         mem_rdata
);
  import spcq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_BITS + ClsW;
  localparam logic [CW-1:0] One  = CW'(1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  seq_state_t        state, state_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     fill, fill_next;
  logic [CW-1:0]     pos, pos_next;
  logic              found, found_next;
  logic              dup, dup_next;
  logic [ID_BITS-1:0] cmd_id, cmd_id_next;
  logic [ClsW-1:0]   cmd_class, cmd_class_next;
  status_e_t         reply, reply_next;

  logic [ID_BITS-1:0] req_id;
  logic [ID_BITS-1:0] rd_id;
  logic [ClsW-1:0]    rd_cls;
  logic [IdW-1:0]     dump_id;
  logic [CW-1:0]      idx_inc;
  logic [CW-1:0]      idx_dec;

  assign rd_id   = mem_rdata[EW-1:ClsW];
  assign rd_cls  = mem_rdata[ClsW-1:0];
  assign idx_inc = idx + One;
  assign idx_dec = idx - One;

  // Port id width to stored id width and back
  generate
    if (ID_BITS >= IdW) begin : g_wide_id
      assign req_id  = ID_BITS'(in_data.patient_id);
      assign dump_id = rd_id[IdW-1:0];
    end else begin : g_narrow_id
      assign req_id  = in_data.patient_id[ID_BITS-1:0];
      assign dump_id = IdW'(rd_id);
    end
  endgenerate

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    pos       <= pos_next;
    found     <= found_next;
    dup       <= dup_next;
    cmd_id    <= cmd_id_next;
    cmd_class <= cmd_class_next;
    reply     <= reply_next;
  end

  // Next state and memory / result control
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    fill_next      = fill;
    pos_next       = pos;
    found_next     = found;
    dup_next       = dup;
    cmd_id_next    = cmd_id;
    cmd_class_next = cmd_class;
    reply_next     = reply;
    mem_we         = 1'b0;
    mem_waddr      = idx[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = idx[AW-1:0];
    res_load       = 1'b0;
    res            = '{status: reply, out_id: '0, out_class: '0, last: 1'b1};

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_id_next    = req_id;
          cmd_class_next = in_data.severity_class;
          idx_next       = '0;
          dup_next       = 1'b0;
          found_next     = 1'b0;
          pos_next       = fill;
          if (in_data.command == CMD_DUMP) begin
            if (fill == '0) begin
              reply_next = ST_EMPTY;
              state_next = S_REPLY;
            end else begin
              state_next = S_DUMP_RD;
            end
          end else if (fill == '0) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end

      // Scan for a duplicate id and the first entry of a lower class
      S_SCAN_RD: begin
        mem_re     = 1'b1;
        state_next = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (rd_id == cmd_id) begin
          dup_next = 1'b1;
        end
        if (!found && (rd_cls < cmd_class)) begin
          found_next = 1'b1;
          pos_next   = idx;
        end
        idx_next   = idx_inc;
        state_next = (idx_inc == fill) ? S_DECIDE : S_SCAN_RD;
      end

      // Checks in order: duplicate, class, full
      S_DECIDE: begin
        idx_next = fill;
        priority if (dup) begin
          reply_next = ST_DUPLICATE;
          state_next = S_REPLY;
        end else if (cmd_class == CLS_INVALID) begin
          reply_next = ST_BAD_CLASS;
          state_next = S_REPLY;
        end else if (fill == Full) begin
          reply_next = ST_FULL;
          state_next = S_REPLY;
        end else if (fill == pos) begin
          state_next = S_PLACE;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end

      // Move entries pos..fill-1 up by one, top first
      S_SHIFT_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_dec[AW-1:0];
        state_next = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = mem_rdata;
        idx_next   = idx_dec;
        state_next = (idx_dec == pos) ? S_PLACE : S_SHIFT_RD;
      end

      S_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[AW-1:0];
        mem_wdata  = {cmd_id, cmd_class};
        fill_next  = fill + One;
        reply_next = ST_INSERTED;
        state_next = S_REPLY;
      end

      // Single result for an insert or an empty dump
      S_REPLY: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Dump: one entry per read, held until the output takes it
      S_DUMP_RD: begin
        mem_re     = 1'b1;
        state_next = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        res = '{status: ST_DUMP, out_id: dump_id, out_class: rd_cls,
                last: (idx_inc == fill)};
        if (out_free) begin
          res_load   = 1'b1;
          idx_next   = idx_inc;
          state_next = (idx_inc == fill) ? S_IDLE : S_DUMP_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/stable_priority_class_queue.sv
// Top level of the stable priority class queue: memory, sequencer, output register.
`timescale 1ns / 1ps
// Keeps up to DEPTH (id, class) entries ordered by class, critical first, and
// by arrival within a class. One request is worked on at a time; in_stall is
// high from acceptance until its last result is loaded into the output
// register. All entries live in one memory with a single read port and
// registered read data, which sets the order of work: an insert scans the
// list, shifts up the entries at and behind its position, writes the new
// entry and replies; a rejected insert scans and replies; and a dump reads
// and outputs one entry at a time, waiting while the output is stalled. The
// output register lets the block go on while a result waits to be taken.
module stable_priority_class_queue #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  spcq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output spcq_pkg::out_item_t out_data
);
  import spcq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = ID_BITS + ClsW;

  logic            out_free;
  logic            res_load;
  out_item_t       res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [EW-1:0]   mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [EW-1:0]   mem_rdata;

  spcq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spcq_seq #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: can take a new result when empty or being drained
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res;
    end
  end

endmodule

FILE: tb/stable_priority_class_queue_tb.sv
// Self-checking testbench for the stable priority class queue: random traffic, predicted replies.
`timescale 1ns / 1ps
module stable_priority_class_queue_tb;
  import spcq_pkg::*;

  localparam int LIST_DEPTH      = 16;
  localparam int RANDOM_REQUESTS = 100;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_AFTER      = 30;
  localparam int TAIL_CYCLES     = 120;
  localparam int TIMEOUT_NS      = 5_000_000;
  localparam int MAX_REPORTS     = 10;

  // Severity codes accepted by the list
  localparam logic [ClsW-1:0] CLS_STABLE   = 2'd0;
  localparam logic [ClsW-1:0] CLS_SERIOUS  = 2'd1;
  localparam logic [ClsW-1:0] CLS_CRITICAL = 2'd2;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  stable_priority_class_queue #(
    .DEPTH   (LIST_DEPTH),
    .ID_BITS (IdW)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Requests still to send, and replies the list owes us
  in_item_t       requests_todo[$];
  out_item_t      replies_due[$];
  logic [IdW-1:0] ids_issued[$];
  int             total_requests;

  // Shadow copy of the ordered list
  logic [IdW-1:0]  list_ids[LIST_DEPTH];
  logic [ClsW-1:0] list_cls[LIST_DEPTH];
  int              list_fill = 0;

  int accepted_cnt = 0;
  int dumps_sent   = 0;
  int replies_seen = 0;
  int bad_cnt      = 0;
  int dup_hits     = 0;
  int class_hits   = 0;
  int full_hits    = 0;

  logic hold_on   = 1'b0;
  logic hold_used = 1'b0;
  int   hold_cnt  = 0;

  // Apply one request to the shadow list and queue the replies it owes
  function automatic void list_apply_request(in_item_t rq);
    out_item_t r;
    int        pos;
    bit        dup;
    r      = '0;
    r.last = 1'b1;
    if (rq.command == CMD_DUMP) begin
      if (list_fill == 0) begin
        r.status = ST_EMPTY;
        replies_due.push_back(r);
      end else begin
        for (int i = 0; i < list_fill; i++) begin
          r.status    = ST_DUMP;
          r.out_id    = list_ids[i];
          r.out_class = list_cls[i];
          r.last      = (i == list_fill - 1);
          replies_due.push_back(r);
        end
      end
      return;
    end
    // duplicate check wins over class check, class check over full check
    dup = 1'b0;
    for (int i = 0; i < list_fill; i++)
      if (list_ids[i] == rq.patient_id) dup = 1'b1;
    if (dup) begin
      r.status = ST_DUPLICATE;
      dup_hits++;
    end else if (rq.severity_class == CLS_INVALID) begin
      r.status = ST_BAD_CLASS;
      class_hits++;
    end else if (list_fill >= LIST_DEPTH) begin
      r.status = ST_FULL;
      full_hits++;
    end else begin
      // goes behind every entry of equal or higher class
      pos = 0;
      while (pos < list_fill && list_cls[pos] >= rq.severity_class) pos++;
      for (int i = list_fill; i > pos; i--) begin
        list_ids[i] = list_ids[i-1];
        list_cls[i] = list_cls[i-1];
      end
      list_ids[pos] = rq.patient_id;
      list_cls[pos] = rq.severity_class;
      list_fill++;
      r.status = ST_INSERTED;
    end
    replies_due.push_back(r);
  endfunction

  function automatic void queue_insert(logic [IdW-1:0] id, logic [ClsW-1:0] cls);
    in_item_t rq;
    rq.command        = CMD_INSERT;
    rq.patient_id     = id;
    rq.severity_class = cls;
    requests_todo.push_back(rq);
    ids_issued.push_back(id);
  endfunction

  function automatic void queue_dump();
    in_item_t rq;
    rq.command        = CMD_DUMP;
    rq.patient_id     = IdW'($urandom);
    rq.severity_class = ClsW'($urandom);
    requests_todo.push_back(rq);
  endfunction

  // Request driver: random gap before each request, with calm stretches
  int gap_left  = 0;
  bit send_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        list_apply_request(in_data);
        accepted_cnt <= accepted_cnt + 1;
        if (in_data.command == CMD_DUMP) dumps_sent <= dumps_sent + 1;
        if (accepted_cnt % 10 == 0) send_calm = ($urandom_range(0, 3) == 0);
        gap_left = send_calm ? 0 : $urandom_range(0, 12);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (requests_todo.size() != 0) begin
          in_data  <= requests_todo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off once, mid-run, so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_on   <= 1'b0;
      hold_used <= 1'b0;
      hold_cnt  <= 0;
    end else if (!hold_used && accepted_cnt >= HOLD_AFTER) begin
      if (hold_cnt == HOLD_CYCLES) begin
        hold_on   <= 1'b0;
        hold_used <= 1'b1;
      end else begin
        hold_on  <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  // Reply monitor: checks each taken reply, then stalls for a random gap
  int        stall_left = 0;
  bit        take_calm  = 1'b0;
  out_item_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen <= replies_seen + 1;
        if (replies_due.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= MAX_REPORTS)
            $display("unexpected reply: status %0d id %h class %0d last %b",
                     out_data.status, out_data.out_id, out_data.out_class, out_data.last);
        end else begin
          want = replies_due.pop_front();
          if (out_data.status !== want.status || out_data.out_id !== want.out_id ||
              out_data.out_class !== want.out_class || out_data.last !== want.last) begin
            bad_cnt++;
            if (bad_cnt <= MAX_REPORTS)
              $display("reply mismatch: got status %0d id %h class %0d last %b,",
                       out_data.status, out_data.out_id, out_data.out_class, out_data.last,
                       " want status %0d id %h class %0d last %b",
                       want.status, want.out_id, want.out_class, want.last);
          end
        end
        if (replies_seen % 10 == 0) take_calm = ($urandom_range(0, 3) == 0);
        stall_left = take_calm ? 0 : $urandom_range(0, 12);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_on || (stall_left > 0);
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    int              roll;
    logic [IdW-1:0]  id;
    logic [ClsW-1:0] cls;

    // directed: empty dump, id extremes, every class, arrival order,
    // duplicate, duplicate with bad class, bad class alone, dump
    queue_dump();
    queue_insert(16'h0000, CLS_STABLE);
    queue_insert(16'hFFFF, CLS_CRITICAL);
    queue_insert(16'h1234, CLS_SERIOUS);
    queue_insert(16'h00FF, CLS_STABLE);
    queue_insert(16'hFF00, CLS_CRITICAL);
    queue_insert(16'h5A5A, CLS_SERIOUS);
    queue_insert(16'h0000, CLS_CRITICAL);
    queue_insert(16'hFFFF, CLS_INVALID);
    queue_insert(16'hA5A5, CLS_INVALID);
    queue_dump();

    // random: mostly inserts of fresh ids, some reused ids and bad classes;
    // the list fills early, so later inserts exercise the full case
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
        queue_dump();
      end else begin
        if ($urandom_range(0, 9) == 0) cls = CLS_INVALID;
        else cls = ClsW'($urandom_range(0, 2));
        if (ids_issued.size() != 0 && $urandom_range(0, 4) == 0)
          id = ids_issued[$urandom_range(0, ids_issued.size() - 1)];
        else
          id = IdW'($urandom);
        queue_insert(id, cls);
      end
    end
    queue_dump();
    total_requests = requests_todo.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total_requests || replies_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d requests (%0d dumps) and %0d replies; list ends with %0d entries",
             accepted_cnt, dumps_sent, replies_seen, list_fill);
    $display("refused inserts: %0d duplicate id, %0d bad class, %0d list full",
             dup_hits, class_hits, full_hits);
    if (bad_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d reply errors", bad_cnt);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
